// ===== rtl/core/lfs_pkg.sv =====
// Shared types and constants for the line field selector.
// Holds the request and result structs, opcode and register codes, and
// the hold drain state type. No dependencies.
package lfs_pkg;

    // Width of a range bound and of the field counter.
    localparam int FW = 13;

    localparam logic [FW-1:0] FIELD_MAX   = 13'd8191;
    localparam logic [FW-1:0] BOUND_OPEN  = 13'd8191;
    localparam logic [7:0]    NEWLINE     = 8'd10;
    localparam logic [7:0]    DELIM_RESET = 8'd9;
    localparam logic [4:0]    COUNT_RESET = 5'd1;

    // Request opcodes.
    typedef enum logic [1:0] {
        OP_DATA  = 2'd0,
        OP_END   = 2'd1,
        OP_RANGE = 2'd2
    } lfs_op_t;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        CFG_FIELD_MODE  = 2'd0,
        CFG_DELIMITER   = 2'd1,
        CFG_SUPPRESS    = 2'd2,
        CFG_RANGE_COUNT = 2'd3
    } lfs_cfg_idx_t;

    // Output sequencer states.
    typedef enum logic [1:0] {
        DR_IDLE,
        DR_HOLD,
        DR_TAIL
    } lfs_drain_t;

    typedef struct packed {
        lfs_op_t         opcode;
        logic [7:0]      data_byte;
        logic [3:0]      range_slot;
        logic [FW-1:0]   range_first;
        logic [FW-1:0]   range_last;
    } lfs_in_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_of_run;
    } lfs_out_t;

endpackage

// ===== rtl/core/line_field_selector.sv =====
// Line field selector: cuts characters or delimited fields out of each text
// line. Top level; depends on lfs_pkg and lfs_range_match.
//
// One request is taken per clock while the sequencer is idle and the output
// register can take a byte. A request that releases held first-field bytes
// (the first delimiter of a line, or a line end without delimiter) holds
// the input while the held bytes and then any trailing delimiter or newline
// leave one per cycle, as the receiver accepts them, through the single read
// port of the hold memory, whose read data is registered. The range
// table is compared in parallel, so table size does not affect throughput.
// Requests pass through the input register and results the output register.
module line_field_selector #(
    parameter int RANGE_ENTRIES = 16,
    parameter int LINE_LIMIT    = 4095,
    parameter int HOLD_DEPTH    = 63
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  lfs_pkg::lfs_in_t in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output lfs_pkg::lfs_out_t out_data,
    input  logic             cfg_we,
    input  logic [1:0]       cfg_index,
    input  logic [7:0]       cfg_data
);
    import lfs_pkg::*;

    localparam int LW = $clog2(LINE_LIMIT + 1);
    localparam int QW = (LW > FW) ? LW : FW;
    localparam int HW = $clog2(HOLD_DEPTH + 1);
    localparam int AW = (HOLD_DEPTH > 1) ? $clog2(HOLD_DEPTH) : 1;

    // Configuration registers.
    logic       field_mode_reg;
    logic [7:0] delim_reg;
    logic       suppress_reg;
    logic [4:0] range_count_reg;

    // Range table.
    logic [FW-1:0] low_reg  [RANGE_ENTRIES];
    logic [FW-1:0] high_reg [RANGE_ENTRIES];

    // Input register.
    logic    s1_valid_reg;
    lfs_in_t s1_item_reg;

    // Line state.
    logic [LW-1:0] line_len_reg,   line_len_next;
    logic [FW-1:0] field_num_reg,  field_num_next;
    logic          delim_seen_reg, delim_seen_next;
    logic          any_emit_reg,   any_emit_next;
    logic [HW-1:0] hold_cnt_reg,   hold_cnt_next;

    // Hold memory and drain sequencer.
    logic [7:0]    hold_mem [HOLD_DEPTH];
    logic [7:0]    hold_q_reg;
    lfs_drain_t    state_reg, state_next;
    logic [HW-1:0] drain_idx_reg, drain_idx_next;
    logic [HW-1:0] drain_len_reg, drain_len_next;
    logic          tail_pend_reg, tail_pend_next;
    logic [7:0]    tail_byte_reg, tail_byte_next;

    // Output register.
    logic     out_valid_reg, out_valid_next;
    lfs_out_t out_item_reg,  out_item_next;

    // Decode signals.
    logic          out_free;
    logic          proc;
    logic [7:0]    b;
    logic          is_delim;
    logic [LW-1:0] line_len_inc;
    logic [FW-1:0] field_inc;
    logic [QW-1:0] query;
    logic          hit_q;
    logic          hit_one;
    logic          want_hold;
    logic          want_tail;
    logic [7:0]    tail_byte;
    logic          hold_we;
    logic          start_drain;
    logic          direct_tail;
    logic          cur_last;
    logic          rd_en;
    logic [AW-1:0] rd_addr;

    // Handshake: a request is processed when the sequencer is idle and the
    // output register can take a byte.
    assign out_free  = !out_valid_reg || out_ready;
    assign proc      = s1_valid_reg && (state_reg == DR_IDLE) && out_free;
    assign in_ready  = !s1_valid_reg || proc;
    assign out_valid = out_valid_reg;
    assign out_data  = out_item_reg;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            field_mode_reg  <= 1'b0;
            delim_reg       <= DELIM_RESET;
            suppress_reg    <= 1'b0;
            range_count_reg <= COUNT_RESET;
        end
        else if (cfg_we)
        begin
            case (lfs_cfg_idx_t'(cfg_index))
                CFG_FIELD_MODE:  field_mode_reg  <= cfg_data[0];
                CFG_DELIMITER:   delim_reg       <= cfg_data;
                CFG_SUPPRESS:    suppress_reg    <= cfg_data[0];
                CFG_RANGE_COUNT: range_count_reg <= cfg_data[4:0];
                default:         ;
            endcase
        end
    end

    // Range table writes; slots beyond the table are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < RANGE_ENTRIES; i++)
            begin
                low_reg[i]  <= '0;
                high_reg[i] <= '0;
            end
        end
        else if (proc && (s1_item_reg.opcode == OP_RANGE))
        begin
            for (int i = 0; i < RANGE_ENTRIES; i++)
            begin
                if ((i < 16) && (s1_item_reg.range_slot == 4'(i)))
                begin
                    low_reg[i]  <= s1_item_reg.range_first;
                    high_reg[i] <= s1_item_reg.range_last;
                end
            end
        end
    end

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            s1_item_reg <= in_data;
        end
    end

    // Query selection for the range compare.
    assign b            = s1_item_reg.data_byte;
    assign is_delim     = (b == delim_reg);
    assign line_len_inc = line_len_reg + LW'(1);
    assign field_inc    = (field_num_reg == FIELD_MAX) ? field_num_reg
                                                       : field_num_reg + FW'(1);

    always_comb
    begin
        if (!field_mode_reg)
        begin
            query = QW'(line_len_inc);
        end
        else if (is_delim)
        begin
            query = QW'(field_inc);
        end
        else
        begin
            query = QW'(field_num_reg);
        end
    end

    lfs_range_match #(
        .ENTRIES (RANGE_ENTRIES),
        .QW      (QW)
    ) u_match (
        .low         (low_reg),
        .high        (high_reg),
        .range_count (range_count_reg),
        .query       (query),
        .hit_query   (hit_q),
        .hit_one     (hit_one)
    );

    // Request decode: next line state and what this request emits.
    always_comb
    begin
        logic end_line;
        logic emit_eff;

        line_len_next   = line_len_reg;
        field_num_next  = field_num_reg;
        delim_seen_next = delim_seen_reg;
        any_emit_next   = any_emit_reg;
        hold_cnt_next   = hold_cnt_reg;
        want_hold       = 1'b0;
        want_tail       = 1'b0;
        tail_byte       = b;
        hold_we         = 1'b0;
        end_line        = 1'b0;
        emit_eff        = any_emit_reg;

        case (s1_item_reg.opcode)
            OP_END:
            begin
                end_line = (line_len_reg != '0);
            end
            OP_DATA:
            begin
                if (b == NEWLINE)
                begin
                    end_line = 1'b1;
                end
                else if (line_len_reg < LW'(LINE_LIMIT))
                begin
                    line_len_next = line_len_inc;
                    if (!field_mode_reg)
                    begin
                        want_tail = hit_q;
                    end
                    else if (is_delim)
                    begin
                        // First delimiter releases the held first field.
                        delim_seen_next = 1'b1;
                        if (!delim_seen_reg && hit_one)
                        begin
                            want_hold = 1'b1;
                            emit_eff  = 1'b1;
                        end
                        field_num_next = field_inc;
                        if (hit_q)
                        begin
                            want_tail = emit_eff;
                            tail_byte = delim_reg;
                            emit_eff  = 1'b1;
                        end
                        any_emit_next = emit_eff;
                    end
                    else if (!delim_seen_reg)
                    begin
                        if (hold_cnt_reg < HW'(HOLD_DEPTH))
                        begin
                            hold_we       = 1'b1;
                            hold_cnt_next = hold_cnt_reg + HW'(1);
                        end
                    end
                    else
                    begin
                        want_tail = hit_q;
                    end
                end
            end
            default:
            begin
            end
        endcase

        // Line end: newline, possibly after the held line, unless a line without a delimiter is suppressed; then clear.
        if (end_line)
        begin
            tail_byte = NEWLINE;
            if (!field_mode_reg || delim_seen_reg)
            begin
                want_tail = 1'b1;
            end
            else if (!suppress_reg)
            begin
                want_hold = 1'b1;
                want_tail = 1'b1;
            end
            line_len_next   = '0;
            field_num_next  = FW'(1);
            delim_seen_next = 1'b0;
            any_emit_next   = 1'b0;
            hold_cnt_next   = '0;
        end
    end

    // Line state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_len_reg   <= '0;
            field_num_reg  <= FW'(1);
            delim_seen_reg <= 1'b0;
            any_emit_reg   <= 1'b0;
            hold_cnt_reg   <= '0;
        end
        else if (proc)
        begin
            line_len_reg   <= line_len_next;
            field_num_reg  <= field_num_next;
            delim_seen_reg <= delim_seen_next;
            any_emit_reg   <= any_emit_next;
            hold_cnt_reg   <= hold_cnt_next;
        end
    end

    assign start_drain = proc && want_hold && (hold_cnt_reg != '0);
    assign direct_tail = proc && want_tail && !start_drain;
    assign cur_last    = (drain_idx_reg == drain_len_reg);

    // Sequencer next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            DR_IDLE:
            begin
                if (start_drain)
                begin
                    state_next = DR_HOLD;
                end
            end
            DR_HOLD:
            begin
                if (out_free && cur_last)
                begin
                    state_next = tail_pend_reg ? DR_TAIL : DR_IDLE;
                end
            end
            DR_TAIL:
            begin
                if (out_free)
                begin
                    state_next = DR_IDLE;
                end
            end
            default:
            begin
                state_next = DR_IDLE;
            end
        endcase
    end

    // Sequencer outputs: memory reads and the output register load.
    always_comb
    begin
        rd_en          = 1'b0;
        rd_addr        = '0;
        drain_idx_next = drain_idx_reg;
        drain_len_next = drain_len_reg;
        tail_pend_next = tail_pend_reg;
        tail_byte_next = tail_byte_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_item_next  = out_item_reg;

        case (state_reg)
            DR_IDLE:
            begin
                if (start_drain)
                begin
                    rd_en          = 1'b1;
                    drain_idx_next = HW'(1);
                    drain_len_next = hold_cnt_reg;
                    tail_pend_next = want_tail;
                    tail_byte_next = tail_byte;
                end
                else if (direct_tail)
                begin
                    out_valid_next = 1'b1;
                    out_item_next  = '{out_byte: tail_byte, last_of_run: 1'b1};
                end
            end
            DR_HOLD:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_item_next  = '{out_byte: hold_q_reg,
                                       last_of_run: cur_last && !tail_pend_reg};
                    if (!cur_last)
                    begin
                        rd_en          = 1'b1;
                        rd_addr        = drain_idx_reg[AW-1:0];
                        drain_idx_next = drain_idx_reg + HW'(1);
                    end
                end
            end
            DR_TAIL:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_item_next  = '{out_byte: tail_byte_reg, last_of_run: 1'b1};
                end
            end
            default:
            begin
            end
        endcase
    end

    // Sequencer and output control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= DR_IDLE;
            out_valid_reg <= 1'b0;
            drain_idx_reg <= '0;
            drain_len_reg <= '0;
            tail_pend_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            drain_idx_reg <= drain_idx_next;
            drain_len_reg <= drain_len_next;
            tail_pend_reg <= tail_pend_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        tail_byte_reg <= tail_byte_next;
        out_item_reg  <= out_item_next;
    end

    // Hold memory: first-field bytes written in order, read back for a drain.
    always_ff @(posedge clk)
    begin
        if (proc && hold_we)
        begin
            hold_mem[hold_cnt_reg[AW-1:0]] <= b;
        end
        if (rd_en)
        begin
            hold_q_reg <= hold_mem[rd_addr];
        end
    end

endmodule

// ===== rtl/core/lfs_range_match.sv =====
// Parallel range table compare for the line field selector.
// Checks one query number and the constant 1 against all active entries.
// Depends on lfs_pkg.
module lfs_range_match #(
    parameter int ENTRIES = 16,
    parameter int QW      = 13
) (
    input  logic [lfs_pkg::FW-1:0] low   [ENTRIES],
    input  logic [lfs_pkg::FW-1:0] high  [ENTRIES],
    input  logic [4:0]             range_count,
    input  logic [QW-1:0]          query,
    output logic                   hit_query,
    output logic                   hit_one
);
    import lfs_pkg::*;

    logic [ENTRIES-1:0] match_q;
    logic [ENTRIES-1:0] match_one;

    // One comparator pair per entry; entries at or above the count stay off.
    for (genvar i = 0; i < ENTRIES; i++) begin : g_entry
        logic active;
        logic open_end;

        if (i < 32) begin : g_live
            assign active = ({1'b0, range_count} > 6'(i));
        end
        else begin : g_dead
            assign active = 1'b0;
        end

        assign open_end = (high[i] == BOUND_OPEN);

        assign match_q[i] = active && (query >= QW'(low[i]))
                            && (open_end || (query <= QW'(high[i])));
        assign match_one[i] = active && (low[i] <= FW'(1))
                              && (open_end || (high[i] >= FW'(1)));
    end

    assign hit_query = |match_q;
    assign hit_one   = |match_one;

endmodule

// ===== sim/line_field_selector_checker.sv =====
`timescale 1ns / 1ps
// Scoreboard for the line field selector: watches the request, result and
// register ports, predicts the expected output text and compares it.
// Depends on lfs_pkg for the request and result types and the codes.
module line_field_selector_checker #(
    parameter int RANGE_ENTRIES = 16,
    parameter int LINE_LIMIT    = 4095,
    parameter int HOLD_DEPTH    = 63
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_ready,
    input  lfs_pkg::lfs_in_t  in_data,
    input  logic              out_valid,
    input  logic              out_ready,
    input  lfs_pkg::lfs_out_t out_data,
    input  logic              cfg_we,
    input  logic [1:0]        cfg_index,
    input  logic [7:0]        cfg_data,
    output int                fail_count,
    output int                pending,
    output int                bytes_checked
);
    import lfs_pkg::*;

    // Shadow copy of the registers.
    bit         field_mode;
    logic [7:0] delim;
    bit         suppress_plain;
    logic [4:0] range_count;

    // Shadow copy of the range table and the per-line state.
    logic [FW-1:0] low_bound [RANGE_ENTRIES];
    logic [FW-1:0] high_bound [RANGE_ENTRIES];
    int unsigned   line_len;
    logic [FW-1:0] field_no;
    bit            delim_seen;
    bit            field_emitted;
    logic [7:0]    hold_mem [HOLD_DEPTH];
    int unsigned   hold_cnt;

    // Bytes produced by the request being predicted, and the expected text.
    logic [7:0] run_bytes [$];
    lfs_out_t   expected_text [$];
    lfs_out_t   want;

    // True when a position or field number lies in any active range.
    function automatic bit selected(input int unsigned n);
        int unsigned cnt;
        cnt = (range_count > RANGE_ENTRIES) ? RANGE_ENTRIES : range_count;
        for (int unsigned i = 0; i < cnt; i++) begin
            if (n >= low_bound[i] && (high_bound[i] == BOUND_OPEN || n <= high_bound[i]))
                return 1'b1;
        end
        return 1'b0;
    endfunction

    task automatic clear_line();
        line_len      = 0;
        field_no      = 1;
        delim_seen    = 1'b0;
        field_emitted = 1'b0;
        hold_cnt      = 0;
    endtask

    task automatic release_hold();
        for (int unsigned i = 0; i < hold_cnt; i++)
            run_bytes.push_back(hold_mem[i]);
    endtask

    // A line end: in field mode a line without delimiter is passed whole
    // unless suppression is on.
    task automatic close_line();
        if (field_mode) begin
            if (delim_seen) begin
                run_bytes.push_back(NEWLINE);
            end
            else if (!suppress_plain) begin
                release_hold();
                run_bytes.push_back(NEWLINE);
            end
        end
        else begin
            run_bytes.push_back(NEWLINE);
        end
        clear_line();
    endtask

    // One text byte; bytes past the line limit are dropped entirely.
    task automatic take_text_byte(input logic [7:0] b);
        if (b == NEWLINE) begin
            close_line();
        end
        else if (line_len < LINE_LIMIT) begin
            line_len++;
            if (!field_mode) begin
                if (selected(line_len))
                    run_bytes.push_back(b);
            end
            else if (b == delim) begin
                // The first delimiter releases the held first field.
                if (!delim_seen) begin
                    delim_seen = 1'b1;
                    if (selected(1)) begin
                        release_hold();
                        field_emitted = 1'b1;
                    end
                end
                if (field_no < FIELD_MAX)
                    field_no++;
                if (selected(field_no)) begin
                    if (field_emitted)
                        run_bytes.push_back(delim);
                    field_emitted = 1'b1;
                end
            end
            else if (!delim_seen) begin
                if (hold_cnt < HOLD_DEPTH) begin
                    hold_mem[hold_cnt] = b;
                    hold_cnt++;
                end
            end
            else if (selected(field_no)) begin
                run_bytes.push_back(b);
            end
        end
    endtask

    // Works out the output bytes of one accepted request and queues them.
    task automatic select_bytes(input lfs_in_t req);
        lfs_out_t item;
        run_bytes.delete();
        case (req.opcode)
            OP_RANGE:
            begin
                low_bound[req.range_slot]  = req.range_first;
                high_bound[req.range_slot] = req.range_last;
            end
            OP_END:
            begin
                if (line_len != 0)
                    close_line();
            end
            OP_DATA:
            begin
                take_text_byte(req.data_byte);
            end
            default:
            begin
            end
        endcase
        foreach (run_bytes[i]) begin
            item.out_byte    = run_bytes[i];
            item.last_of_run = (i == run_bytes.size() - 1);
            expected_text.push_back(item);
        end
    endtask

    task automatic note_mismatch(input string msg);
        fail_count++;
        if (fail_count <= 10)
            $display("%0t ns: %s", $time, msg);
    endtask

    // Sample all ports at the rising edge; results are checked before the
    // request of the same edge is predicted.
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            field_mode     = 1'b0;
            delim          = DELIM_RESET;
            suppress_plain = 1'b0;
            range_count    = COUNT_RESET;
            for (int i = 0; i < RANGE_ENTRIES; i++) begin
                low_bound[i]  = '0;
                high_bound[i] = '0;
            end
            clear_line();
            expected_text.delete();
            fail_count    = 0;
            bytes_checked = 0;
        end
        else begin
            if (out_valid && out_ready) begin
                bytes_checked++;
                if (expected_text.size() == 0) begin
                    note_mismatch($sformatf("output byte %02h (last %0b) with nothing expected",
                                            out_data.out_byte, out_data.last_of_run));
                end
                else begin
                    want = expected_text.pop_front();
                    if (out_data.out_byte !== want.out_byte ||
                        out_data.last_of_run !== want.last_of_run)
                        note_mismatch($sformatf("expected byte %02h last %0b, got byte %02h last %0b",
                                                want.out_byte, want.last_of_run,
                                                out_data.out_byte, out_data.last_of_run));
                end
            end
            if (in_valid && in_ready)
                select_bytes(in_data);
            if (cfg_we) begin
                case (lfs_cfg_idx_t'(cfg_index))
                    CFG_FIELD_MODE:  field_mode     = cfg_data[0];
                    CFG_DELIMITER:   delim          = cfg_data;
                    CFG_SUPPRESS:    suppress_plain = cfg_data[0];
                    CFG_RANGE_COUNT: range_count    = cfg_data[4:0];
                    default:
                    begin
                    end
                endcase
            end
        end
        pending = expected_text.size();
    end

endmodule

// ===== sim/tb_line_field_selector.sv =====
`timescale 1ns / 1ps
// Top of the line field selector testbench: clock, reset, request and
// register stimulus, and the verdict. Depends on lfs_pkg, the block and
// line_field_selector_checker.
module tb_line_field_selector;
    import lfs_pkg::*;

    localparam int RANGE_ENTRIES = 16;
    localparam int LINE_LIMIT    = 4095;
    localparam int HOLD_DEPTH    = 63;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int DRAIN_CYCLES  = 80;
    localparam int PHASE_ITEMS   = 5;
    localparam int PHASES        = 8;
    localparam lfs_op_t OP_UNUSED = lfs_op_t'(2'd3);

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    logic       in_ready;
    lfs_in_t    in_data   = '0;
    logic       out_valid;
    logic       out_ready = 1'b1;
    lfs_out_t   out_data;
    logic       cfg_we    = 1'b0;
    logic [1:0] cfg_index = '0;
    logic [7:0] cfg_data  = '0;

    bit         idle_on       = 1'b1;
    bit         cur_mode      = 1'b0;
    logic [7:0] cur_delim     = DELIM_RESET;
    int         requests_sent = 0;
    int         settings_run  = 0;
    int         cycle_count   = 0;
    int         fail_count;
    int         pending;
    int         bytes_checked;

    line_field_selector #(
        .RANGE_ENTRIES(RANGE_ENTRIES),
        .LINE_LIMIT   (LINE_LIMIT),
        .HOLD_DEPTH   (HOLD_DEPTH)
    ) DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data (out_data),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    line_field_selector_checker #(
        .RANGE_ENTRIES(RANGE_ENTRIES),
        .LINE_LIMIT   (LINE_LIMIT),
        .HOLD_DEPTH   (HOLD_DEPTH)
    ) checker_i (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .in_data      (in_data),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_data     (out_data),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .fail_count   (fail_count),
        .pending      (pending),
        .bytes_checked(bytes_checked)
    );

    always #4 clk = ~clk;

    // The receiver stalls now and then, except in the quiet stretch.
    always @(negedge clk)
        out_ready = !(idle_on && ($urandom_range(99) < 11));

    // Watchdog on the whole run.
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Run stopped after %0d cycles with %0d bytes outstanding.",
                     cycle_count, pending);
            $display("Verification failed");
            $finish;
        end
    end

    // A request with every field random; callers overwrite what matters.
    function automatic lfs_in_t noise_request();
        logic [39:0] raw;
        raw = {8'($urandom_range(255)), $urandom};
        return lfs_in_t'(raw);
    endfunction

    // Entered and left at a falling edge; valid stays up between requests
    // unless the sender idles.
    task automatic push_request(input lfs_in_t req);
        int gap;
        if (idle_on && $urandom_range(99) < 11) begin
            in_valid = 1'b0;
            gap = $urandom_range(1, 4);
            repeat (gap) @(negedge clk);
        end
        in_valid = 1'b1;
        in_data  = req;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        requests_sent++;
        @(negedge clk);
    endtask

    task automatic send_byte(input logic [7:0] b);
        lfs_in_t req;
        req = noise_request();
        req.opcode    = OP_DATA;
        req.data_byte = b;
        push_request(req);
    endtask

    task automatic send_op(input lfs_op_t op);
        lfs_in_t req;
        req = noise_request();
        req.opcode = op;
        push_request(req);
    endtask

    task automatic send_range(input logic [3:0] slot, input logic [FW-1:0] first,
                              input logic [FW-1:0] last);
        lfs_in_t req;
        req = noise_request();
        req.opcode      = OP_RANGE;
        req.range_slot  = slot;
        req.range_first = first;
        req.range_last  = last;
        push_request(req);
    endtask

    // Mostly small bounds so that selections happen, sometimes full width.
    task automatic random_range_entry();
        logic [FW-1:0] first;
        logic [FW-1:0] last;
        int            pick;
        first = ($urandom_range(99) < 70) ? FW'($urandom_range(0, 6)) : FW'($urandom);
        pick  = $urandom_range(99);
        if (pick < 40)
            last = BOUND_OPEN;
        else if (pick < 80)
            last = first + FW'($urandom_range(0, 4));
        else
            last = FW'($urandom);
        send_range(4'($urandom), first, last);
    endtask

    // Waits until every expected byte is out and the block has gone quiet.
    task automatic settle();
        in_valid = 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input lfs_cfg_idx_t idx, input logic [7:0] value);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        @(negedge clk);
        cfg_we = 1'b0;
        if (idx == CFG_FIELD_MODE)
            cur_mode = value[0];
        if (idx == CFG_DELIMITER)
            cur_delim = value;
    endtask

    // One line of random text; in field mode a delimiter sits at position head
    // when that lies inside the line, and more may follow. The line ends with a newline, an
    // end of input, or stays open into the next setting.
    task automatic send_random_line(input int len, input int head);
        logic [7:0] b;
        int         pick;
        for (int i = 0; i < len; i++) begin
            if ($urandom_range(99) < 6) begin
                if ($urandom_range(99) < 50)
                    send_op(OP_UNUSED);
                else
                    random_range_entry();
            end
            if (cur_mode && i == head)
                b = cur_delim;
            else if (cur_mode && i > head && $urandom_range(99) < 20)
                b = cur_delim;
            else
                b = 8'($urandom_range(255));
            send_byte(b);
        end
        pick = $urandom_range(99);
        if (pick < 75)
            send_byte(NEWLINE);
        else if (pick < 87)
            send_op(OP_END);
    endtask

    initial begin
        logic       mode;
        logic [7:0] delim;
        logic       suppress;
        logic [4:0] count;
        int         start;
        int         len;
        int         head;

        repeat (5) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed part, starting from the reset settings: an empty table
        // entry selects nothing, and a bare end of input yields nothing.
        send_byte("a");
        send_byte(NEWLINE);
        send_op(OP_END);
        send_op(OP_UNUSED);
        send_range(4'd0, '0, BOUND_OPEN);
        send_range(4'd15, FIELD_MAX, FIELD_MAX);
        send_byte(8'hFF);
        send_byte(8'h00);
        send_op(OP_END);

        // Field mode with the zero byte as delimiter, all sixteen entries.
        settle();
        write_reg(CFG_RANGE_COUNT, 8'd16);
        write_reg(CFG_FIELD_MODE, 8'd1);
        write_reg(CFG_DELIMITER, 8'd0);
        settings_run++;
        send_byte("a");
        send_byte(8'h00);
        send_byte("b");
        send_byte(NEWLINE);
        send_byte("q");
        send_byte(NEWLINE);

        // A line with no delimiter is dropped once suppression is on.
        settle();
        write_reg(CFG_SUPPRESS, 8'd1);
        settings_run++;
        send_byte("z");
        send_op(OP_END);

        // Switch to character mode in the middle of a line.
        send_byte("m");
        settle();
        write_reg(CFG_FIELD_MODE, 8'd0);
        settings_run++;
        send_byte("n");
        send_byte(NEWLINE);

        // A range count of zero selects nothing.
        settle();
        write_reg(CFG_RANGE_COUNT, 8'd0);
        settings_run++;
        send_byte("c");
        send_byte(NEWLINE);

        // Random part: several register settings, each with fresh table
        // entries and random lines.
        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0:
                begin
                    mode = 1'b0; delim = DELIM_RESET; suppress = 1'b0; count = COUNT_RESET;
                end
                1:
                begin
                    mode = 1'b1; delim = 8'd0; suppress = 1'b0; count = 5'd16;
                end
                2:
                begin
                    mode = 1'b1; delim = 8'hFF; suppress = 1'b1; count = 5'd31;
                end
                3:
                begin
                    mode = 1'b1; delim = NEWLINE; suppress = 1'b0; count = 5'd0;
                end
                4:
                begin
                    mode = 1'b0; delim = 8'($urandom_range(255)); suppress = 1'b1;
                    count = 5'd17;
                end
                5:
                begin
                    mode = 1'b1; delim = 8'($urandom_range(255)); suppress = 1'b1;
                    count = 5'($urandom_range(31));
                end
                6:
                begin
                    mode = 1'b1; delim = ","; suppress = 1'b0; count = 5'd2;
                end
                default:
                begin
                    mode = 1'b1; delim = DELIM_RESET; suppress = 1'($urandom_range(1));
                    count = 5'($urandom_range(1, 16));
                end
            endcase
            idle_on = (p != 5);
            settle();
            write_reg(CFG_FIELD_MODE, {7'd0, mode});
            write_reg(CFG_DELIMITER, delim);
            write_reg(CFG_SUPPRESS, {7'd0, suppress});
            write_reg(CFG_RANGE_COUNT, {3'd0, count});
            settings_run++;
            repeat (2) random_range_entry();

            // A first field longer than the hold store: only its leading
            // bytes come back out.
            if (p == 6) begin
                send_range(4'd0, FW'(1), FW'(1));
                send_random_line($urandom_range(66, 70), $urandom_range(64, 65));
            end

            start = requests_sent;
            while (requests_sent - start < PHASE_ITEMS) begin
                len  = $urandom_range(0, 8);
                head = $urandom_range(0, len);
                send_random_line(len, head);
            end
        end

        // Flush whatever line is still open, then drain.
        send_op(OP_END);
        idle_on = 1'b1;
        settle();

        $display("Sent %0d requests under %0d register settings; %0d output bytes checked.",
                 requests_sent, settings_run, bytes_checked);
        $display("Character and field modes, lines without delimiter and a first field longer than the hold store were covered.");
        if (fail_count == 0 && pending == 0) begin
            $display("Verification passed");
        end
        else begin
            $display("%0d mismatches, %0d bytes never arrived.", fail_count, pending);
            $display("Verification failed");
        end
        $finish;
    end

endmodule
